// ===== hw/rtl/wtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtp_pkg
// Shared types, register map, divider sizes and waypoint tables for the
// waypoint trajectory player.
// ----------------------------------------------------------------------------
package wtp_pkg;

  // input transaction
  typedef struct packed {
    logic        mode;
    logic [15:0] elapsed_time;
  } wtp_in_t;

  // result transaction
  typedef struct packed {
    logic [8:0] pos_x;
    logic [8:0] pos_y;
    logic       finished;
  } wtp_out_t;

  // configuration register contents
  typedef struct packed {
    logic        interpolate_enable;
    logic [15:0] tick_length;
  } wtp_cfg_t;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_INTERP = 1'b0;
  localparam logic REG_TICK   = 1'b1;
  localparam logic [15:0] TICK_LENGTH_RST = 16'd1000;

  localparam logic MODE_TIME  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // shared divider sizes: numerator covers rem * |b - a| (16 x 9 bits)
  localparam int unsigned DIV_NUM_W = 25;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } wtp_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } wtp_div_rsp_t;

  function automatic logic [8:0] wp_x(input logic [4:0] idx);
    logic [8:0] v;
    case (idx)
      5'd0:  v = 9'd0;
      5'd1:  v = 9'd6;
      5'd2:  v = 9'd13;
      5'd3:  v = 9'd19;
      5'd4:  v = 9'd26;
      5'd5:  v = 9'd32;
      5'd6:  v = 9'd38;
      5'd7:  v = 9'd45;
      5'd8:  v = 9'd51;
      5'd9:  v = 9'd58;
      5'd10: v = 9'd64;
      5'd11: v = 9'd77;
      5'd12: v = 9'd102;
      5'd13: v = 9'd134;
      5'd14: v = 9'd160;
      5'd15: v = 9'd186;
      5'd16: v = 9'd205;
      5'd17: v = 9'd218;
      5'd18: v = 9'd224;
      5'd19: v = 9'd230;
      5'd20: v = 9'd237;
      5'd21: v = 9'd256;
      5'd22: v = 9'd269;
      5'd23: v = 9'd282;
      5'd24: v = 9'd294;
      5'd25: v = 9'd307;
      5'd26: v = 9'd314;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] wp_y(input logic [4:0] idx);
    logic [8:0] v;
    case (idx)
      5'd0:  v = 9'd420;
      5'd1:  v = 9'd398;
      5'd2:  v = 9'd378;
      5'd3:  v = 9'd362;
      5'd4:  v = 9'd348;
      5'd5:  v = 9'd336;
      5'd6:  v = 9'd327;
      5'd7:  v = 9'd319;
      5'd8:  v = 9'd312;
      5'd9:  v = 9'd307;
      5'd10: v = 9'd303;
      5'd11: v = 9'd298;
      5'd12: v = 9'd294;
      5'd13: v = 9'd295;
      5'd14: v = 9'd297;
      5'd15: v = 9'd300;
      5'd16: v = 9'd304;
      5'd17: v = 9'd308;
      5'd18: v = 9'd310;
      5'd19: v = 9'd313;
      5'd20: v = 9'd316;
      5'd21: v = 9'd330;
      5'd22: v = 9'd342;
      5'd23: v = 9'd357;
      5'd24: v = 9'd375;
      5'd25: v = 9'd396;
      5'd26: v = 9'd408;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/wtp_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtp_cfg
// APB-style register file: interpolation enable and tick length.
// ----------------------------------------------------------------------------
module wtp_cfg
  import wtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output wtp_cfg_t           cfg
);

  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // word select only, byte lane bits ignored
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interpolate_enable <= 1'b0;
      cfg.tick_length        <= TICK_LENGTH_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_INTERP: cfg.interpolate_enable <= pwdata[0];
        REG_TICK:   cfg.tick_length        <= pwdata[15:0];
        default:    cfg.tick_length        <= cfg.tick_length;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INTERP: prdata = {31'd0, cfg.interpolate_enable};
      REG_TICK:   prdata = {16'd0, cfg.tick_length};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/wtp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtp_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtp_div
  import wtp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  wtp_div_req_t req,
  output wtp_div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 qbit;

  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign qbit    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits DIV_DEN_W bits
      rem <= qbit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], qbit};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== hw/rtl/waypoint_trajectory_player.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_trajectory_player
// Plays back a fixed table of 2-D waypoints, optionally interpolating.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data): mode = start restarts playback
//   from point 0 and gives no result; mode = time adds elapsed_time and
//   gives one position transaction on the out channel.
//   APB port: reg 0 (addr 0) interpolate_enable, reg 1 (addr 4) tick_length.
//   A start item, or a time item while finished, is handled without the
//   divider. A time item while running uses the shared restoring divider
//   for the tick division and, when interpolating, for the x and y blends.
//   One item is worked on at a time: in_stall is high from acceptance until
//   the result has been taken. A start item may be accepted while no
//   result is pending.
//   While out_stall is high the result holds in the output register.
//   Reset: playback idle, point 0, remainder 0, interpolation off,
//   tick length 1000.
// ----------------------------------------------------------------------------
module waypoint_trajectory_player
  import wtp_pkg::*;
#(
  parameter int unsigned NUM_POINTS = 27
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  wtp_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wtp_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TICK = 3'd1;
  localparam logic [2:0] ST_MULX = 3'd2;
  localparam logic [2:0] ST_DIVX = 3'd3;
  localparam logic [2:0] ST_MULY = 3'd4;
  localparam logic [2:0] ST_DIVY = 3'd5;

  localparam logic [4:0] LAST_IDX = 5'(NUM_POINTS - 1);

  wtp_cfg_t     cfg;
  wtp_div_req_t div_req;
  wtp_div_rsp_t div_rsp;

  logic [2:0]           state;
  logic [4:0]           point_index;
  logic [15:0]          time_remainder;
  logic                 running_flag;
  logic                 div_go;
  logic [DIV_NUM_W-1:0] num;
  logic                 neg;
  logic [8:0]           base;
  logic [8:0]           pos_x;

  logic        in_acc;
  logic        out_acc;
  logic [15:0] len;
  logic [16:0] ticks;
  logic [5:0]  idx_sum;
  logic        run_end;
  logic        blend_on;
  logic [4:0]  next_idx;
  logic [8:0]  pa;
  logic [8:0]  pb;
  logic [8:0]  absdiff;
  logic [8:0]  delta;
  logic [8:0]  blend_res;

  wtp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // zero tick length acts as one
  assign len = (cfg.tick_length == 16'd0) ? 16'd1 : cfg.tick_length;

  assign div_req.start    = div_go;
  assign div_req.dividend = num;
  assign div_req.divisor  = len;

  assign in_stall = (state != ST_IDLE) || out_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign ticks    = div_rsp.quotient[16:0];
  assign idx_sum  = {1'b0, point_index} + {1'b0, ticks[4:0]};
  assign run_end  = (ticks >= 17'(NUM_POINTS)) || (idx_sum >= 6'(NUM_POINTS));
  assign blend_on = cfg.interpolate_enable && (idx_sum < 6'(NUM_POINTS - 1));
  assign next_idx = point_index + 5'd1;

  always_comb begin
    if (state == ST_MULY) begin
      pa = wp_y(point_index);
      pb = wp_y(next_idx);
    end else begin
      pa = wp_x(point_index);
      pb = wp_x(next_idx);
    end
  end
  assign absdiff = (pb >= pa) ? (pb - pa) : (pa - pb);

  // negative slope rounds toward minus infinity
  assign delta = div_rsp.quotient[8:0]
               + {8'd0, neg && (div_rsp.remainder != '0)};
  assign blend_res = neg ? (base - delta) : (base + delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      point_index    <= '0;
      time_remainder <= '0;
      running_flag   <= 1'b0;
      div_go         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_acc) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.mode == MODE_START) begin
              point_index    <= '0;
              time_remainder <= '0;
              running_flag   <= 1'b1;
            end else if (!running_flag) begin
              out_data  <= '{pos_x: wp_x(LAST_IDX), pos_y: wp_y(LAST_IDX),
                             finished: 1'b1};
              out_valid <= 1'b1;
            end else begin
              num    <= DIV_NUM_W'({1'b0, time_remainder} + {1'b0, in_data.elapsed_time});
              div_go <= 1'b1;
              state  <= ST_TICK;
            end
          end
        end
        ST_TICK: begin
          if (div_rsp.done) begin
            time_remainder <= div_rsp.remainder;
            if (run_end) begin
              point_index  <= LAST_IDX;
              running_flag <= 1'b0;
              out_data     <= '{pos_x: wp_x(LAST_IDX), pos_y: wp_y(LAST_IDX),
                                finished: 1'b1};
              out_valid    <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              point_index <= idx_sum[4:0];
              if (blend_on) begin
                state <= ST_MULX;
              end else begin
                out_data  <= '{pos_x: wp_x(idx_sum[4:0]), pos_y: wp_y(idx_sum[4:0]),
                               finished: 1'b0};
                out_valid <= 1'b1;
                state     <= ST_IDLE;
              end
            end
          end
        end
        ST_MULX, ST_MULY: begin
          num    <= {9'd0, time_remainder} * {16'd0, absdiff};
          neg    <= (pb < pa);
          base   <= pa;
          div_go <= 1'b1;
          state  <= (state == ST_MULX) ? ST_DIVX : ST_DIVY;
        end
        ST_DIVX: begin
          if (div_rsp.done) begin
            pos_x <= blend_res;
            state <= ST_MULY;
          end
        end
        ST_DIVY: begin
          if (div_rsp.done) begin
            out_data  <= '{pos_x: pos_x, pos_y: blend_res, finished: 1'b0};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (state == ST_IDLE) && !out_valid)
    else $error("item accepted while busy");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    running_flag |-> (point_index < 5'(NUM_POINTS)))
    else $error("point index out of range while running");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_TICK) || (state == ST_DIVX) || (state == ST_DIVY))
    else $error("divider finished outside a divide state");

  a_running_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.finished) |-> running_flag)
    else $error("unfinished result while playback idle");
`endif

endmodule

// ===== tb/sv/tb_waypoint_trajectory_player.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waypoint_trajectory_player
// Self-checking bench for the waypoint player. A cycle-free tracker of the
// playback state computes the expected position of every accepted time
// transaction. Results are compared in order against that queue. Directed
// checks cover the corners; random playbacks then run across several settings
// with random gaps and stalls on both channels, but for one quiet run.
// ----------------------------------------------------------------------------
module tb_waypoint_trajectory_player
  import wtp_pkg::*;
();

  localparam int unsigned NPTS    = 27;
  localparam int unsigned LAST_PT = NPTS - 1;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  wtp_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wtp_out_t           out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  waypoint_trajectory_player #(.NUM_POINTS(NPTS)) u_top (.*);

  // waypoint table, entries past the point count read as the origin
  bit [8:0] way_x [32] = '{
    0, 6, 13, 19, 26, 32, 38, 45, 51, 58, 64, 77, 102, 134,
    160, 186, 205, 218, 224, 230, 237, 256, 269, 282, 294, 307, 314,
    0, 0, 0, 0, 0};
  bit [8:0] way_y [32] = '{
    420, 398, 378, 362, 348, 336, 327, 319, 312, 307, 303, 298, 294, 295,
    297, 300, 304, 308, 310, 313, 316, 330, 342, 357, 375, 396, 408,
    0, 0, 0, 0, 0};

  // tracked playback state and register copies
  bit           cfg_interp = 1'b0;
  bit [15:0]    cfg_tick   = TICK_LENGTH_RST;
  int unsigned  pidx       = 0;
  int unsigned  prem       = 0;
  bit           playing    = 1'b0;

  wtp_out_t     expected_pos [$];
  wtp_out_t     want;
  int           errors     = 0;
  bit           calm       = 1'b0;
  int           hold_left  = 0;
  int           stall_left = 0;
  bit           stall_now  = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  // a + floor(rem * (b - a) / len), floor toward minus infinity
  function automatic bit [8:0] blend_axis(bit [8:0] a, bit [8:0] b, longint rem,
                                          longint len);
    longint num, q;
    num = rem * (longint'(b) - longint'(a));
    if (num >= 0) q = num / len;
    else q = -((-num + len - 1) / len);
    return 9'(longint'(a) + q);
  endfunction

  task automatic track_step(wtp_in_t d);
    longint      len;
    int unsigned total, steps, nxt;
    wtp_out_t    r;
    if (d.mode == MODE_START) begin
      pidx = 0;
      prem = 0;
      playing = 1'b1;
      return;
    end
    r = '{pos_x: way_x[LAST_PT], pos_y: way_y[LAST_PT], finished: 1'b1};
    if (playing) begin
      len = (cfg_tick == 0) ? 1 : cfg_tick;
      total = prem + d.elapsed_time;
      steps = total / len;
      prem = total % len;
      nxt = pidx + steps;
      if (nxt >= NPTS) begin
        pidx = LAST_PT;
        playing = 1'b0;
      end else begin
        pidx = nxt;
        if (cfg_interp && pidx + 1 < NPTS)
          r = '{pos_x: blend_axis(way_x[pidx], way_x[pidx + 1], prem, len),
                pos_y: blend_axis(way_y[pidx], way_y[pidx + 1], prem, len),
                finished: 1'b0};
        else
          r = '{pos_x: way_x[pidx], pos_y: way_y[pidx], finished: 1'b0};
      end
    end
    expected_pos.push_back(r);
  endtask

  // receiver: random stalls, or a counted long hold when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        if (stall_now) begin
          stall_now = 1'b0;
          stall_left = $urandom_range(1, 12);
        end else begin
          stall_left = pick_gap();
          stall_now = (stall_left > 0);
          if (!stall_now) stall_left = $urandom_range(1, 8);
        end
      end
      stall_left--;
      out_stall <= stall_now;
    end
  end

  task automatic check_field(string name, logic [8:0] exp_v, logic [8:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pos.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual x %0d y %0d fin %0d",
                 $time, out_data.pos_x, out_data.pos_y, out_data.finished);
      end else begin
        want = expected_pos.pop_front();
        check_field("pos_x", want.pos_x, out_data.pos_x);
        check_field("pos_y", want.pos_y, out_data.pos_y);
        check_field("finished", 9'(want.finished), 9'(out_data.finished));
      end
    end
  end

  // entered and left at a falling edge; valid stays up for a back-to-back item
  task automatic offer_step(wtp_in_t d);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_step(d);
    @(negedge clk);
  endtask

  task automatic send_start();
    offer_step('{mode: MODE_START, elapsed_time: 16'($urandom_range(0, 65535))});
  endtask

  task automatic send_time(int unsigned dt);
    offer_step('{mode: MODE_TIME, elapsed_time: 16'(dt)});
  endtask

  // start items give no result, so the queue alone cannot show that the last one is done
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pos.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write then read back one register
  task automatic reg_access(logic idx, logic [31:0] val);
    logic [31:0] exp_rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_INTERP) cfg_interp = val[0];
    else cfg_tick = val[15:0];
    exp_rd = (idx == REG_INTERP) ? {31'b0, cfg_interp} : {16'b0, cfg_tick};
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== exp_rd) begin
      errors++;
      $display("%0t: register %0d readback, expected %0d, actual %0d",
               $time, idx, exp_rd, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(bit interp, int unsigned tick);
    wait_idle();
    reg_access(REG_INTERP, 32'(interp));
    reg_access(REG_TICK, 32'(tick));
  endtask

  task automatic test_idle_after_reset();
    send_time(0);
    send_time(16'hFFFF);
  endtask

  // reset settings: hold each point, 1000 units per step
  task automatic test_hold_points();
    send_start();
    send_time(0);
    send_time(999);
    send_time(1);
    send_time(65535);
    send_time(5);
  endtask

  task automatic test_interpolation();
    set_config(1'b1, 4);
    send_start();
    send_time(1);
    send_time(2);
    send_time(3);
    set_config(1'b1, 65535);
    send_start();
    send_time(65535);
    send_time(65534);
    send_time(65535);
  endtask

  // zero tick length acts as one; last point has no successor to blend toward
  task automatic test_zero_tick();
    set_config(1'b1, 0);
    send_start();
    send_time(3);
    send_time(23);
    send_time(0);
    send_time(1);
  endtask

  // leftover remainder gets divided by the new tick length
  task automatic test_tick_change();
    set_config(1'b1, 1000);
    send_start();
    send_time(2500);
    set_config(1'b1, 300);
    send_time(100);
    send_time(950);
    set_config(1'b0, 1000);
    send_time(990);
    set_config(1'b0, 30);
    send_time(0);
  endtask

  function automatic int unsigned pick_elapsed();
    int unsigned len, lim;
    int r;
    len = (cfg_tick == 0) ? 1 : cfg_tick;
    lim = (2 * len > 65535) ? 65535 : 2 * len;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, lim);
    if (r < 88) return $urandom_range(0, len / 4);
    if (r < 97) return $urandom_range(0, 65535);
    return (r < 99) ? 0 : 65535;
  endfunction

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    set_config(1'b1, 1000);
    send_start();
    hold_left = 300;
    repeat (12) send_time(pick_elapsed());
    wait_idle();
  endtask

  task automatic test_random_playback(bit interp, int unsigned tick, int count,
                                      bit quiet);
    int want_start;
    set_config(interp, tick);
    calm = quiet;
    repeat (count) begin
      want_start = playing ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 99) < 85);
      if (want_start) send_start();
      else send_time(pick_elapsed());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_idle_after_reset();
    test_hold_points();
    test_interpolation();
    test_zero_tick();
    test_tick_change();
    test_backpressure();
    test_random_playback(1'b0, 1000, 100, 1'b0);
    test_random_playback(1'b1, 1000, 120, 1'b1);
    test_random_playback(1'b1, 1, 60, 1'b0);
    test_random_playback(1'b1, 65535, 80, 1'b0);
    test_random_playback(1'b0, 0, 60, 1'b0);
    test_random_playback(1'b1, $urandom_range(2, 60), 100, 1'b0);
    test_random_playback(1'b1, $urandom_range(100, 5000), 100, 1'b0);
    test_random_playback(1'b0, $urandom_range(1, 65535), 80, 1'b0);
    wait_idle();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
